// ----- rtl/rpe_pkg.sv -----
// ---------------------------------------------------------------------------
// rpe_pkg
// shared types, constants and tables of the rotary position embedding block
// ---------------------------------------------------------------------------
`default_nettype none
package rpe_pkg;

   localparam int PAIRS         = 64;
   localparam int MAX_POSITION  = 32768;
   localparam int CORDIC_STAGES = 24;
   localparam int PAIR_AW       = $clog2(PAIRS);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

   localparam logic [61:0] INV_TWO_PI_Q64  = 62'h28BE60DB9391054A;
   localparam logic [32:0] TWO_PI_Q30      = 33'h1921FB544;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_KEY    = 2'd2,
      REQ_IGNORE = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic               is_query;
      logic [14:0]        position;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic [19:0]        query_scale;
      logic [31:0]        freq;
   } job_type;

   typedef struct packed {
      logic                  empty;
      logic [QUEUE_AW:0]     count;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- rtl/rpe_ram.sv -----
// ---------------------------------------------------------------------------
// rpe_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none
module rpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/rpe_front.sv -----
// ---------------------------------------------------------------------------
// rpe_front
// accepts transactions, writes and reads the frequency table, feeds the queue
// ---------------------------------------------------------------------------
`default_nettype none
module rpe_front
   import rpe_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire [1:0]         req_type,
   input  wire [5:0]         pair_index,
   input  wire [14:0]        position,
   input  wire [31:0]        first_value,
   input  wire [31:0]        second_value,
   input  wire [19:0]        query_scale,
   input  wire [31:0]        freq_word,
   input  queue_status_type  queue_status,
   output logic              push,
   output job_type           push_job
);

   logic        accept;
   logic        is_load;
   logic        is_rot;
   logic        slot_ok;
   logic [31:0] rd_data;
   logic        stage_v_ff, stage_v_in;
   job_type     stage_ff, stage_in;
   logic        stage_ok_ff, stage_ok_in;

   assign req_tready = (QUEUE_AW+2)'(queue_status.count) + (QUEUE_AW+2)'(stage_v_ff)
                       < (QUEUE_AW+2)'(QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;
   assign slot_ok = 9'(pair_index) < 9'(PAIRS);

   always_comb begin
      is_load = 1'b0;
      is_rot  = 1'b0;
      case (req_kind_type'(req_type))
         REQ_LOAD:  is_load = 1'b1;
         REQ_QUERY: is_rot = 1'b1;
         REQ_KEY:   is_rot = 1'b1;
         default:   is_rot = 1'b0;
      endcase
   end

   rpe_ram #(.WIDTH(32), .DEPTH(PAIRS)) u_table (
      .clock   (clock),
      .wr_en   (accept && is_load && slot_ok),
      .wr_addr (pair_index[PAIR_AW-1:0]),
      .wr_data (freq_word),
      .rd_en   (accept && is_rot),
      .rd_addr (pair_index[PAIR_AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      stage_v_in  = accept && is_rot;
      stage_ok_in = slot_ok;
      stage_in.is_query     = (req_kind_type'(req_type) == REQ_QUERY);
      stage_in.position     = (17'(position) >= 17'(MAX_POSITION)) ?
                              15'(MAX_POSITION - 1) : position;
      stage_in.first_value  = first_value;
      stage_in.second_value = second_value;
      stage_in.query_scale  = query_scale;
      stage_in.freq         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
      end else begin
         stage_v_ff <= stage_v_in;
      end
      if (stage_v_in) begin
         stage_ff    <= stage_in;
         stage_ok_ff <= stage_ok_in;
      end
   end

   always_comb begin
      push          = stage_v_ff;
      push_job      = stage_ff;
      push_job.freq = stage_ok_ff ? rd_data : 32'd0;
   end

endmodule
`default_nettype wire

// ----- rtl/rpe_queue.sv -----
// ---------------------------------------------------------------------------
// rpe_queue
// short fifo between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none
module rpe_queue
   import rpe_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  job_type           push_job,
   input  wire               pop,
   output job_type           head_job,
   output queue_status_type  status
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_pop;

   assign do_pop = pop && (count_ff != '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/rpe_back.sv -----
// ---------------------------------------------------------------------------
// rpe_back
// angle, phase reduction, pipelined cordic, rotation, scaling and saturation
// ---------------------------------------------------------------------------
`default_nettype none
module rpe_back
   import rpe_pkg::*;
(
   input  wire                queue_empty,
   input  job_type            head_job,
   output logic               pop,
   input  wire                clock,
   input  wire                reset,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [31:0]        rotated_first,
   output logic [31:0]        rotated_second,
   output logic               saturated
);

   typedef struct packed {
      logic               is_query;
      logic [19:0]        scale;
      logic signed [31:0] x1;
      logic signed [31:0] x2;
   } pay_type;

   localparam int NS = CORDIC_STAGES;

   logic    en;
   pay_type head_pay;

   // angle product
   logic        v0_ff;
   pay_type     p0_ff;
   logic [46:0] prod_ff;
   // partial products
   logic        v1_ff;
   pay_type     p1_ff;
   logic [54:0] pp0_ff, pp1_ff;
   logic [53:0] pp2_ff, pp3_ff;
   // partial sums
   logic        v2_ff;
   pay_type     p2_ff;
   logic [94:0] sa_ff, sb_ff, sa_in, sb_in;
   // phase
   logic        v3_ff;
   pay_type     p3_ff;
   logic [31:0] phase_ff;
   logic [94:0] full_sum;
   // fold
   logic        v4_ff;
   pay_type     p4_ff;
   logic [30:0] fold_ff, fold_in;
   logic        ns4_ff, nc4_ff, ns_in, nc_in;
   logic [31:0] neg_phase;
   // radians
   logic        v5_ff;
   pay_type     p5_ff;
   logic        ns5_ff, nc5_ff;
   logic [63:0] zprod;
   logic signed [33:0] z5_ff;
   // cordic
   logic               cv_ff [NS];
   pay_type            cp_ff [NS];
   logic               cns_ff [NS];
   logic               cnc_ff [NS];
   logic signed [33:0] cx_ff [NS];
   logic signed [33:0] cy_ff [NS];
   logic signed [33:0] cz_ff [NS];
   // signs applied
   logic        v6_ff;
   pay_type     p6_ff;
   logic signed [33:0] c6_ff, s6_ff;
   // products
   logic        v7_ff;
   logic        q7_ff;
   logic [19:0] sc7_ff;
   logic signed [65:0] m1_ff, m2_ff, m3_ff, m4_ff;
   // rounded rotation
   logic        v8_ff;
   logic        q8_ff;
   logic [19:0] sc8_ff;
   logic signed [36:0] r1_ff, r2_ff;
   logic signed [66:0] d1, d2;
   // scaled
   logic        v9_ff;
   logic        q9_ff;
   logic signed [36:0] r1_9_ff, r2_9_ff;
   logic signed [57:0] s1_ff, s2_ff;
   logic signed [41:0] f1, f2;
   // output
   logic        out_v_ff;
   logic [31:0] o1_ff, o2_ff, o1_in, o2_in;
   logic        sat_ff, sat_in;

   assign en  = !out_v_ff || rsp_tready;
   assign pop = en && !queue_empty;

   assign head_pay.is_query = head_job.is_query;
   assign head_pay.scale    = head_job.query_scale;
   assign head_pay.x1       = head_job.first_value;
   assign head_pay.x2       = head_job.second_value;

   always_comb begin
      sa_in = 95'(pp0_ff) + (95'(pp1_ff) << 31);
      sb_in = (95'(pp2_ff) << 24) + (95'(pp3_ff) << 55);
      full_sum = sa_ff + sb_ff;
      neg_phase = 32'd0 - phase_ff;
      ns_in = phase_ff[31];
      fold_in = '0;
      nc_in = 1'b0;
      if (ns_in) begin
         if (neg_phase > 32'h40000000) begin
            nc_in = 1'b1;
            fold_in = 31'(32'h80000000 - neg_phase);
         end else begin
            fold_in = neg_phase[30:0];
         end
      end else if (phase_ff > 32'h40000000) begin
         nc_in = 1'b1;
         fold_in = 31'(32'h80000000 - phase_ff);
      end else begin
         fold_in = phase_ff[30:0];
      end
      zprod = 64'(fold_ff) * 64'(TWO_PI_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= pop;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         p0_ff   <= head_pay;
         prod_ff <= 47'(head_job.position) * 47'(head_job.freq);
         p1_ff   <= p0_ff;
         pp0_ff  <= 55'(prod_ff[23:0]) * 55'(INV_TWO_PI_Q64[30:0]);
         pp1_ff  <= 55'(prod_ff[23:0]) * 55'(INV_TWO_PI_Q64[61:31]);
         pp2_ff  <= 54'(prod_ff[46:24]) * 54'(INV_TWO_PI_Q64[30:0]);
         pp3_ff  <= 54'(prod_ff[46:24]) * 54'(INV_TWO_PI_Q64[61:31]);
         p2_ff   <= p1_ff;
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         p3_ff   <= p2_ff;
         phase_ff <= full_sum[94:63];
         p4_ff   <= p3_ff;
         fold_ff <= fold_in;
         ns4_ff  <= ns_in;
         nc4_ff  <= nc_in;
         p5_ff   <= p4_ff;
         ns5_ff  <= ns4_ff;
         nc5_ff  <= nc4_ff;
         z5_ff   <= $signed(34'(zprod[63:32]));
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      logic               pv;
      pay_type            pp;
      logic               pns, pnc;
      logic signed [33:0] px, py, pz, xs, ys, nx, ny, nz;
      logic signed [33:0] at;

      if (i == 0) begin : g_first
         assign pv  = v5_ff;
         assign pp  = p5_ff;
         assign pns = ns5_ff;
         assign pnc = nc5_ff;
         assign px  = CORDIC_GAIN_Q30;
         assign py  = '0;
         assign pz  = z5_ff;
      end else begin : g_next
         assign pv  = cv_ff[i-1];
         assign pp  = cp_ff[i-1];
         assign pns = cns_ff[i-1];
         assign pnc = cnc_ff[i-1];
         assign px  = cx_ff[i-1];
         assign py  = cy_ff[i-1];
         assign pz  = cz_ff[i-1];
      end

      assign at = $signed(34'(ATAN_Q30[i]));
      assign xs = px >>> i;
      assign ys = py >>> i;

      always_comb begin
         if (!pz[33]) begin
            nx = px - ys;
            ny = py + xs;
            nz = pz - at;
         end else begin
            nx = px + ys;
            ny = py - xs;
            nz = pz + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (en) begin
            cv_ff[i] <= pv;
         end
         if (en) begin
            cp_ff[i]  <= pp;
            cns_ff[i] <= pns;
            cnc_ff[i] <= pnc;
            cx_ff[i]  <= nx;
            cy_ff[i]  <= ny;
            cz_ff[i]  <= nz;
         end
      end
   end

   always_comb begin
      d1 = 67'(m1_ff) - 67'(m2_ff);
      d2 = 67'(m3_ff) + 67'(m4_ff);
      f1 = q9_ff ? 42'((s1_ff + 58'sd32768) >>> 16) : 42'(r1_9_ff);
      f2 = q9_ff ? 42'((s2_ff + 58'sd32768) >>> 16) : 42'(r2_9_ff);
      sat_in = 1'b0;
      if (f1 > 42'sd2147483647) begin
         o1_in = 32'h7FFFFFFF;
         sat_in = 1'b1;
      end else if (f1 < -42'sd2147483648) begin
         o1_in = 32'h80000000;
         sat_in = 1'b1;
      end else begin
         o1_in = f1[31:0];
      end
      if (f2 > 42'sd2147483647) begin
         o2_in = 32'h7FFFFFFF;
         sat_in = 1'b1;
      end else if (f2 < -42'sd2147483648) begin
         o2_in = 32'h80000000;
         sat_in = 1'b1;
      end else begin
         o2_in = f2[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff    <= 1'b0;
         v7_ff    <= 1'b0;
         v8_ff    <= 1'b0;
         v9_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v6_ff    <= cv_ff[NS-1];
         v7_ff    <= v6_ff;
         v8_ff    <= v7_ff;
         v9_ff    <= v8_ff;
         out_v_ff <= v9_ff;
      end
      if (en) begin
         p6_ff  <= cp_ff[NS-1];
         c6_ff  <= cnc_ff[NS-1] ? -cx_ff[NS-1] : cx_ff[NS-1];
         s6_ff  <= cns_ff[NS-1] ? -cy_ff[NS-1] : cy_ff[NS-1];
         q7_ff  <= p6_ff.is_query;
         sc7_ff <= p6_ff.scale;
         m1_ff  <= 66'(p6_ff.x1) * 66'(c6_ff);
         m2_ff  <= 66'(p6_ff.x2) * 66'(s6_ff);
         m3_ff  <= 66'(p6_ff.x2) * 66'(c6_ff);
         m4_ff  <= 66'(p6_ff.x1) * 66'(s6_ff);
         q8_ff  <= q7_ff;
         sc8_ff <= sc7_ff;
         r1_ff  <= 37'((d1 + 67'sd536870912) >>> 30);
         r2_ff  <= 37'((d2 + 67'sd536870912) >>> 30);
         q9_ff  <= q8_ff;
         r1_9_ff <= r1_ff;
         r2_9_ff <= r2_ff;
         s1_ff  <= 58'(r1_ff) * $signed(58'(sc8_ff));
         s2_ff  <= 58'(r2_ff) * $signed(58'(sc8_ff));
         o1_ff  <= o1_in;
         o2_ff  <= o2_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid     = out_v_ff;
   assign rotated_first  = o1_ff;
   assign rotated_second = o2_ff;
   assign saturated      = sat_ff;

endmodule
`default_nettype wire

// ----- rtl/rotary_position_embedding.sv -----
// ---------------------------------------------------------------------------
// rotary_position_embedding
// rotates one element pair of a query or key vector by a position angle
// ---------------------------------------------------------------------------
//  channel | direction | tdata                            | tuser
//  req     | in        | index, position, x1, x2, scale,  | request type
//          |           | frequency                        |
//  rsp     | out       | rotated first, rotated second    | saturated
//
//  one transaction per cycle sustained, set by the fully pipelined back end, while
//  rsp_tready is high; accept to rsp_tvalid runs through table read, queue,
//  phase multiply, 24 cordic stages, rotation, scaling and saturation
//  loads and type 3 produce no response; a load writes the table on accept
//  rsp_tready low on a valid response freezes the whole back end; the queue
//  then fills and req_tready drops; synchronous reset clears control only, table undefined
`default_nettype none
module rotary_position_embedding
   import rpe_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_tvalid,
   output logic          req_tready,
   // index[5:0] position[20:6] first[52:21] second[84:53] scale[104:85] freq[136:105]
   input  wire [143:0]   req_tdata,
   // req_type[1:0]
   input  wire [1:0]     req_tuser,
   output logic          rsp_tvalid,
   input  wire           rsp_tready,
   // rotated_first[31:0] rotated_second[63:32]
   output logic [63:0]   rsp_tdata,
   // saturated[0]
   output logic [0:0]    rsp_tuser
);

   queue_status_type qstat;
   logic             push, pop;
   job_type          push_job, head_job;
   logic [31:0]      r1, r2;
   logic             sat;

   rpe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_type     (req_tuser),
      .pair_index   (req_tdata[5:0]),
      .position     (req_tdata[20:6]),
      .first_value  (req_tdata[52:21]),
      .second_value (req_tdata[84:53]),
      .query_scale  (req_tdata[104:85]),
      .freq_word    (req_tdata[136:105]),
      .queue_status (qstat),
      .push         (push),
      .push_job     (push_job)
   );

   rpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (qstat)
   );

   rpe_back u_back (
      .queue_empty    (qstat.empty),
      .head_job       (head_job),
      .pop            (pop),
      .clock          (clock),
      .reset          (reset),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rotated_first  (r1),
      .rotated_second (r2),
      .saturated      (sat)
   );

   assign rsp_tdata = {r2, r1};
   assign rsp_tuser = sat;

endmodule
`default_nettype wire

// ----- bench/rotary_position_embedding_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rotary_position_embedding_checker
// watches both channels, keeps a copy of the frequency table, predicts each
// rotated pair with a bit-exact phase reduction and cordic, compares in order
// ---------------------------------------------------------------------------
module rotary_position_embedding_checker
   import rpe_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire [143:0]  req_tdata,
   input  wire [1:0]    req_tuser,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire [63:0]   rsp_tdata,
   input  wire [0:0]    rsp_tuser,
   output int           fail_count,
   output int           pending_count
);

   typedef struct packed {
      logic [31:0] first;
      logic [31:0] second;
      logic        sat;
   } rotated_pair_type;

   logic [31:0]      freq_copy [PAIRS];
   rotated_pair_type rotated_queue [$];

   assign pending_count = rotated_queue.size();

   function automatic longint round_down(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic logic [31:0] clip(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic rotated_pair_type rotate_pair(logic [143:0] d, req_kind_type kind);
      logic [14:0]   pos;
      logic [63:0]   angle;
      logic [127:0]  turns;
      logic [31:0]   phase;
      logic          neg_sin, neg_cos, sat;
      longint        x, y, z, xs, ys, c, s, a1, a2, r1, r2, sc;
      rotated_pair_type res;
      pos = d[20:6];
      angle = 64'(pos) * 64'(freq_copy[d[5:0]]);
      turns = 128'(angle) * 128'(INV_TWO_PI_Q64);
      phase = turns[94:63];
      neg_sin = 1'b0;
      neg_cos = 1'b0;
      if (phase[31]) begin
         neg_sin = 1'b1;
         phase = 32'd0 - phase;
      end
      if (phase > 32'h40000000) begin
         neg_cos = 1'b1;
         phase = 32'h80000000 - phase;
      end
      z = longint'((64'(phase) * 64'(TWO_PI_Q30)) >> 32);
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
         end
      end
      c = neg_cos ? -x : x;
      s = neg_sin ? -y : y;
      a1 = longint'($signed(d[52:21]));
      a2 = longint'($signed(d[84:53]));
      r1 = round_down(a1 * c - a2 * s, 30);
      r2 = round_down(a2 * c + a1 * s, 30);
      if (kind == REQ_QUERY) begin
         sc = longint'(d[104:85]);
         r1 = round_down(r1 * sc, 16);
         r2 = round_down(r2 * sc, 16);
      end
      sat = 1'b0;
      res.first = clip(r1, sat);
      res.second = clip(r2, sat);
      res.sat = sat;
      return res;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rotated_pair_type want;
      if (!reset && req_tvalid && req_tready) begin
         case (req_kind_type'(req_tuser))
            REQ_LOAD: freq_copy[req_tdata[5:0]] = req_tdata[136:105];
            REQ_QUERY, REQ_KEY:
               rotated_queue.push_back(rotate_pair(req_tdata, req_kind_type'(req_tuser)));
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rotated_queue.size() == 0) begin
            report("unexpected transaction", rsp_tdata[31:0], 32'd0);
         end else begin
            want = rotated_queue.pop_front();
            if (rsp_tdata[31:0] !== want.first)
               report("rotated_first", rsp_tdata[31:0], want.first);
            if (rsp_tdata[63:32] !== want.second)
               report("rotated_second", rsp_tdata[63:32], want.second);
            if (rsp_tuser[0] !== want.sat)
               report("saturated", 32'(rsp_tuser), 32'(want.sat));
         end
      end
   end

endmodule

// ----- bench/rotary_position_embedding_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rotary_position_embedding_tb
// loads the frequency table, then streams directed and random query and key
// pairs with random idling on both sides; a checker compares every response
// ---------------------------------------------------------------------------
module rotary_position_embedding_tb;
   import rpe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [63:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;
   int            fail_count;
   int            pending_count;
   int            cycle_count;
   logic          idle_free;

   rotary_position_embedding i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   rotary_position_embedding_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .fail_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic int draw_wait();
      return idle_free ? 0 : $urandom_range(17, 0);
   endfunction

   function automatic logic [31:0] draw_value();
      case ($urandom_range(5, 0))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(255, 0) << 16;
         3: return 32'(signed'($urandom_range(65536 * 8, 0)) - 65536 * 4);
         default: return $urandom();
      endcase
   endfunction

   task automatic send(req_kind_type kind, logic [5:0] index, logic [14:0] pos,
                       logic [31:0] a1, logic [31:0] a2, logic [19:0] scale,
                       logic [31:0] freq);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, freq, scale, a2, a1, pos, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_rotate(req_kind_type kind);
      send(kind, 6'($urandom()), 15'($urandom()), draw_value(), draw_value(),
           $urandom_range(1, 0) ? 20'h10000 + 20'($urandom_range(4095, 0)) : 20'($urandom()),
           $urandom());
   endtask

   initial begin
      req_kind_type kind;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_IGNORE;
      rsp_tready = 1'b0;
      idle_free = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // fill every slot before any rotate
      for (int i = 0; i < PAIRS; i++) begin
         send(REQ_LOAD, 6'(i), 15'($urandom()), $urandom(), $urandom(), $urandom(),
              i == 0 ? 32'h80000000 : i == 1 ? 32'd0 : i == 2 ? 32'hffffffff :
              32'h80000000 >> (i % 20));
      end
      // directed: extremes, both kinds, ignored type, a reload
      send(REQ_QUERY, 6'd0, 15'h7fff, 32'h7fffffff, 32'h80000000, 20'hfffff, 32'd0);
      send(REQ_KEY,   6'd0, 15'h7fff, 32'h80000000, 32'h80000000, 20'd0, 32'd0);
      send(REQ_QUERY, 6'd1, 15'd0, 32'h80000000, 32'h7fffffff, 20'd0, 32'd0);
      send(REQ_KEY,   6'd1, 15'd1234, 32'h00010000, 32'hffff0000, 20'd0, 32'd0);
      send(REQ_KEY,   6'd2, 15'h7fff, 32'h7fffffff, 32'h7fffffff, 20'd0, 32'd0);
      send(REQ_QUERY, 6'd2, 15'd1, 32'h00010000, 32'd0, 20'h10000, 32'd0);
      send(REQ_QUERY, 6'd63, 15'h5555, 32'h55555555, 32'haaaaaaaa, 20'h55555, 32'd0);
      send(REQ_KEY,   6'd42, 15'h2aaa, 32'haaaaaaaa, 32'h55555555, 20'haaaaa, 32'd0);
      send(REQ_IGNORE, 6'd3, 15'd7, 32'h1, 32'h2, 20'h3, 32'hffffffff);
      send(REQ_LOAD,  6'd3, 15'd0, 32'd0, 32'd0, 20'd0, 32'h00001000);
      send(REQ_KEY,   6'd3, 15'd9, 32'h00020000, 32'h00030000, 20'd0, 32'd0);
      // hold off until the pipeline drains
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      for (int n = 0; n < 1530; n++) begin
         if (n % 300 == 150) idle_free = ~idle_free;
         case ($urandom_range(19, 0))
            0, 1: send(REQ_LOAD, 6'($urandom()), 15'($urandom()), $urandom(), $urandom(),
                       $urandom(), $urandom());
            2: send(REQ_IGNORE, 6'($urandom()), 15'($urandom()), $urandom(), $urandom(),
                    $urandom(), $urandom());
            default: begin
               kind = $urandom_range(1, 0) ? REQ_QUERY : REQ_KEY;
               send_rotate(kind);
            end
         endcase
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // response side stalls
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_wait();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

endmodule
